// ----- src/lrp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_pkg: shared types and constants of the LR parse engine
// Item codes, action kinds, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package lrp_pkg;

	localparam int MAX_STATES_DEF      = 1024;
	localparam int MAX_SYMBOLS_DEF     = 128;
	localparam int MAX_PRODUCTIONS_DEF = 256;
	localparam int STACK_DEPTH_DEF     = 256;
	localparam int PENDING_DEPTH_DEF   = 4;
	localparam int MAX_STEPS_DEF       = 64;

	localparam logic [1:0] MODE_LOAD_ACT  = 2'd0;
	localparam logic [1:0] MODE_LOAD_PROD = 2'd1;
	localparam logic [1:0] MODE_TOKEN     = 2'd2;
	localparam logic [1:0] MODE_RESTART   = 2'd3;

	localparam logic [2:0] KIND_ACCEPT = 3'd0;
	localparam logic [2:0] KIND_ERROR  = 3'd1;
	localparam logic [2:0] KIND_SHIFT  = 3'd2;
	localparam logic [2:0] KIND_ESHIFT = 3'd3;
	localparam logic [2:0] KIND_REDUCE = 3'd4;
	localparam logic [2:0] KIND_EREDUC = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ACCEPTED = 3'd1;
	localparam logic [2:0] ST_SYNTAX   = 3'd2;
	localparam logic [2:0] ST_INVALID  = 3'd3;
	localparam logic [2:0] ST_STACK    = 3'd4;
	localparam logic [2:0] ST_PENDING  = 3'd5;
	localparam logic [2:0] ST_STEPS    = 3'd6;
	localparam logic [2:0] ST_IGNORED  = 3'd7;

	localparam logic [6:0] MAX_REDS = 7'd64;

	typedef enum logic [1:0] {
		OP_LOAD_ACT,
		OP_LOAD_PROD,
		OP_TOKEN,
		OP_RESTART
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       ld_ok;
		logic [9:0] state_index;
		logic [6:0] symbol;
		logic [2:0] action_kind;
		logic [9:0] action_target;
		logic [7:0] production_index;
		logic [6:0] production_left;
		logic [4:0] production_length;
	} item_t;

	typedef struct packed {
		logic  vld;
		item_t item;
	} q_head_t;

endpackage
`default_nettype wire

// ----- src/lrp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_front: command intake
// Accepts items, classifies them and range-checks loads into a two-entry queue.
// ----------------------------------------------------------------------------
module lrp_front import lrp_pkg::*; #(
	parameter int MAX_STATES      = MAX_STATES_DEF,
	parameter int MAX_SYMBOLS     = MAX_SYMBOLS_DEF,
	parameter int MAX_PRODUCTIONS = MAX_PRODUCTIONS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] mode,
	input  wire logic [9:0] state_index,
	input  wire logic [6:0] symbol,
	input  wire logic [2:0] action_kind,
	input  wire logic [9:0] action_target,
	input  wire logic [7:0] production_index,
	input  wire logic [6:0] production_left,
	input  wire logic [4:0] production_length,
	input  wire logic       pop,
	output q_head_t         head
);

	item_t       fifo_q [2];
	logic        wptr_q, rptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	item_t       cls;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign head.vld  = (cnt_q != 2'd0);
	assign head.item = fifo_q[rptr_q];

	always_comb begin
		cls.state_index       = state_index;
		cls.symbol            = symbol;
		cls.action_kind       = action_kind;
		cls.action_target     = action_target;
		cls.production_index  = production_index;
		cls.production_left   = production_left;
		cls.production_length = production_length;
		cls.ld_ok = 1'b0;
		case (mode)
			MODE_LOAD_ACT: begin
				cls.op = OP_LOAD_ACT;
				cls.ld_ok = (32'(state_index) < 32'(MAX_STATES)) &&
				            (32'(symbol) < 32'(MAX_SYMBOLS));
			end
			MODE_LOAD_PROD: begin
				cls.op = OP_LOAD_PROD;
				cls.ld_ok = (32'(production_index) < 32'(MAX_PRODUCTIONS));
			end
			MODE_TOKEN: cls.op = OP_TOKEN;
			default:    cls.op = OP_RESTART;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/lrp_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_engine: parse back end
// Owns the tables and stacks, executes loads, restarts and token action loops.
// ----------------------------------------------------------------------------
module lrp_engine import lrp_pkg::*; #(
	parameter int MAX_STATES      = MAX_STATES_DEF,
	parameter int MAX_SYMBOLS     = MAX_SYMBOLS_DEF,
	parameter int MAX_PRODUCTIONS = MAX_PRODUCTIONS_DEF,
	parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
	parameter int PENDING_DEPTH   = PENDING_DEPTH_DEF,
	parameter int MAX_STEPS       = MAX_STEPS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_head_t head,
	output logic      pop,
	output logic       done,
	output logic [2:0] status,
	output logic [6:0] reductions_done,
	output logic [7:0] last_production,
	output logic [8:0] stack_depth
);

	localparam int AW  = $clog2(MAX_STATES * MAX_SYMBOLS);
	localparam int PW  = (MAX_PRODUCTIONS > 1) ? $clog2(MAX_PRODUCTIONS) : 1;
	localparam int SW  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PCW = $clog2(PENDING_DEPTH + 1);
	localparam int STW = $clog2(MAX_STEPS + 1);

	typedef struct packed {
		logic [2:0] kind;
		logic [9:0] tgt;
	} act_ent_t;

	typedef struct packed {
		logic [6:0] left;
		logic [4:0] len;
	} prod_ent_t;

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_ACT, S_PROD, S_POP} state_t;

	act_ent_t  act_mem [MAX_STATES * MAX_SYMBOLS];
	prod_ent_t prod_mem [MAX_PRODUCTIONS];
	logic [9:0] stk_mem [STACK_DEPTH];
	act_ent_t   act_rd_q;
	prod_ent_t  prod_rd_q;
	logic [9:0] stk_rd_q;

	state_t     state_q;
	logic [SPW-1:0] sp_q;
	logic [9:0]     top_q;
	logic [PCW-1:0] pcnt_q;
	logic [6:0]     pend_q [PENDING_DEPTH];
	logic [1:0]     phase_q;
	logic [STW-1:0] steps_q;
	logic [6:0]     reds_q;
	logic [7:0]     lastp_q;
	logic [2:0]     kind_q;
	logic [9:0]     tgt_q;
	logic           tok_q;
	logic           done_q;
	logic [2:0]     status_q;

	localparam logic [1:0] PH_RUN = 2'd0;
	localparam logic [1:0] PH_ACC = 2'd1;
	localparam logic [1:0] PH_ERR = 2'd2;

	item_t          it;
	logic [6:0]     pend_top;
	logic           look_bad, act_re, act_we, prod_re, prod_we, stk_we, stk_re;
	logic [AW-1:0]  act_raddr, act_waddr;
	logic [4:0]     red_len;
	logic [SPW-1:0] new_sp;
	logic           red_ok;
	logic           is_shift, is_red;

	assign it       = head.item;
	assign pop      = (state_q == S_IDLE) && head.vld;
	assign pend_top = pend_q[PIW'(pcnt_q - 1'b1)];
	assign look_bad = (32'(top_q) >= 32'(MAX_STATES)) || (32'(pend_top) >= 32'(MAX_SYMBOLS));
	assign act_raddr = AW'(32'(top_q) * 32'(MAX_SYMBOLS) + 32'(pend_top));
	assign act_waddr = AW'(32'(it.state_index) * 32'(MAX_SYMBOLS) + 32'(it.symbol));
	assign act_re = (state_q == S_LOOK) && (pcnt_q != '0) &&
	                (32'(steps_q) != 32'(MAX_STEPS)) && !look_bad;
	assign act_we  = pop && (it.op == OP_LOAD_ACT) && it.ld_ok;
	assign prod_we = pop && (it.op == OP_LOAD_PROD) && it.ld_ok;
	assign is_shift = (act_rd_q.kind == KIND_SHIFT) || (act_rd_q.kind == KIND_ESHIFT);
	assign is_red   = (act_rd_q.kind == KIND_REDUCE) || (act_rd_q.kind == KIND_EREDUC);
	assign prod_re = (state_q == S_ACT) && is_red &&
	                 (32'(act_rd_q.tgt) < 32'(MAX_PRODUCTIONS));
	assign stk_we  = (state_q == S_ACT) && is_shift && (32'(sp_q) < 32'(STACK_DEPTH));
	assign red_len = (kind_q == KIND_REDUCE) ? prod_rd_q.len : 5'd1;
	assign new_sp  = sp_q - SPW'(red_len);
	assign red_ok  = (32'(red_len) < 32'(sp_q)) && (32'(pcnt_q) < 32'(PENDING_DEPTH));
	assign stk_re  = (state_q == S_PROD) && red_ok && (new_sp != SPW'(1));

	always_ff @(posedge clk) begin
		if (act_we) act_mem[act_waddr] <= '{kind: it.action_kind, tgt: it.action_target};
		if (act_re) act_rd_q <= act_mem[act_raddr];
	end

	always_ff @(posedge clk) begin
		if (prod_we) prod_mem[PW'(it.production_index)] <=
			'{left: it.production_left, len: it.production_length};
		if (prod_re) prod_rd_q <= prod_mem[PW'(act_rd_q.tgt)];
	end

	// entry zero is never written or read: state 0 at the stack bottom is loaded into top_q directly
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[SW'(sp_q)] <= act_rd_q.tgt;
		if (stk_re) stk_rd_q <= stk_mem[SW'(new_sp - SPW'(1))];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop && it.op == OP_TOKEN && phase_q == PH_RUN &&
		    32'(pcnt_q) < 32'(PENDING_DEPTH))
			pend_q[PIW'(pcnt_q)] <= it.symbol;
		else if (state_q == S_PROD && red_ok)
			pend_q[PIW'(pcnt_q)] <= prod_rd_q.left;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sp_q     <= SPW'(1);
			top_q    <= '0;
			pcnt_q   <= '0;
			phase_q  <= PH_RUN;
			steps_q  <= '0;
			reds_q   <= '0;
			lastp_q  <= '0;
			kind_q   <= '0;
			tgt_q    <= '0;
			tok_q    <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						reds_q  <= '0;
						lastp_q <= '0;
						steps_q <= '0;
						tok_q   <= 1'b0;
						case (it.op)
							OP_RESTART: begin
								sp_q <= SPW'(1);
								top_q <= '0;
								pcnt_q <= '0;
								phase_q <= PH_RUN;
								done_q <= 1'b1;
								status_q <= ST_OK;
							end
							OP_TOKEN: begin
								if (phase_q != PH_RUN) begin
									done_q <= 1'b1;
									status_q <= ST_IGNORED;
								end else if (32'(pcnt_q) >= 32'(PENDING_DEPTH)) begin
									done_q <= 1'b1;
									status_q <= ST_PENDING;
									phase_q <= PH_ERR;
								end else begin
									pcnt_q <= pcnt_q + 1'b1;
									tok_q <= 1'b1;
									state_q <= S_LOOK;
								end
							end
							default: begin
								done_q <= 1'b1;
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_LOOK: begin
					if (pcnt_q == '0 || 32'(steps_q) == 32'(MAX_STEPS) || look_bad) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
						if (pcnt_q == '0) begin
							status_q <= ST_OK;
						end else begin
							status_q <= look_bad && 32'(steps_q) != 32'(MAX_STEPS) ?
							            ST_INVALID : ST_STEPS;
							phase_q <= PH_ERR;
						end
					end else begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					kind_q <= act_rd_q.kind;
					tgt_q  <= act_rd_q.tgt;
					state_q <= S_IDLE;
					if (is_shift) begin
						if (stk_we) begin
							sp_q <= sp_q + 1'b1;
							top_q <= act_rd_q.tgt;
							if (act_rd_q.kind == KIND_SHIFT) pcnt_q <= pcnt_q - 1'b1;
							steps_q <= steps_q + 1'b1;
							state_q <= S_LOOK;
						end else begin
							done_q <= 1'b1;
							status_q <= ST_STACK;
							phase_q <= PH_ERR;
						end
					end else if (is_red) begin
						if (prod_re) begin
							state_q <= S_PROD;
						end else begin
							done_q <= 1'b1;
							status_q <= ST_INVALID;
							phase_q <= PH_ERR;
						end
					end else begin
						done_q <= 1'b1;
						case (act_rd_q.kind)
							KIND_ACCEPT: begin
								status_q <= ST_ACCEPTED;
								phase_q <= PH_ACC;
							end
							KIND_ERROR: begin
								status_q <= ST_SYNTAX;
								phase_q <= PH_ERR;
							end
							default: begin
								status_q <= ST_INVALID;
								phase_q <= PH_ERR;
							end
						endcase
					end
				end
				S_PROD: begin
					if (red_ok) begin
						sp_q <= new_sp;
						pcnt_q <= pcnt_q + 1'b1;
						reds_q <= reds_q + 7'd1;
						lastp_q <= tgt_q[7:0];
						steps_q <= steps_q + 1'b1;
						if (new_sp == SPW'(1)) begin
							top_q <= '0;
							state_q <= S_LOOK;
						end else begin
							state_q <= S_POP;
						end
					end else begin
						done_q <= 1'b1;
						status_q <= (32'(red_len) >= 32'(sp_q)) ? ST_STACK : ST_PENDING;
						phase_q <= PH_ERR;
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					top_q <= stk_rd_q;
					state_q <= S_LOOK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign reductions_done = tok_q ? reds_q : 7'd0;
	assign last_production = tok_q ? lastp_q : 8'd0;
	assign stack_depth     = 9'(sp_q);

endmodule
`default_nettype wire

// ----- src/lr_parse_engine_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lr_parse_engine_top: table-driven LR parse engine
// Front intake queue feeding the parse back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive mode and the item fields with start high; the beat is
//   taken at an edge where busy is low. A two-entry queue sits behind the port.
//   Result channel: done pulses for one cycle with status, reductions_done,
//   last_production and stack_depth; the receiver cannot stall it and must
//   capture the beat in that cycle. Results come in input order, one per item.
// Processing:
//   Loads and restarts complete in the engine's idle state. A token runs
//   an action loop: a shift reads the action table and pushes; a reduction
//   reads the action, production and, unless the stack drops to state 0,
//   stack memories. The engine takes a new item only when back in idle.
// Reset:
//   arst_n clears the queue and the parse state: one stack entry (state 0),
//   nothing pending, parse running. Tables are undefined until loaded.
// ----------------------------------------------------------------------------
module lr_parse_engine_top import lrp_pkg::*; #(
	parameter int MAX_STATES      = MAX_STATES_DEF,
	parameter int MAX_SYMBOLS     = MAX_SYMBOLS_DEF,
	parameter int MAX_PRODUCTIONS = MAX_PRODUCTIONS_DEF,
	parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
	parameter int PENDING_DEPTH   = PENDING_DEPTH_DEF,
	parameter int MAX_STEPS       = MAX_STEPS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] mode,
	input  wire logic [9:0] state_index,
	input  wire logic [6:0] symbol,
	input  wire logic [2:0] action_kind,
	input  wire logic [9:0] action_target,
	input  wire logic [7:0] production_index,
	input  wire logic [6:0] production_left,
	input  wire logic [4:0] production_length,
	output logic            done,
	output logic [2:0]      status,
	output logic [6:0]      reductions_done,
	output logic [7:0]      last_production,
	output logic [8:0]      stack_depth
);

	q_head_t head;
	logic    pop;

	lrp_front #(
		.MAX_STATES(MAX_STATES), .MAX_SYMBOLS(MAX_SYMBOLS),
		.MAX_PRODUCTIONS(MAX_PRODUCTIONS)
	) u_front (
		.clk, .arst_n, .start, .busy, .mode, .state_index, .symbol,
		.action_kind, .action_target, .production_index, .production_left,
		.production_length, .pop, .head
	);

	lrp_engine #(
		.MAX_STATES(MAX_STATES), .MAX_SYMBOLS(MAX_SYMBOLS),
		.MAX_PRODUCTIONS(MAX_PRODUCTIONS), .STACK_DEPTH(STACK_DEPTH),
		.PENDING_DEPTH(PENDING_DEPTH), .MAX_STEPS(MAX_STEPS)
	) u_engine (
		.clk, .arst_n, .head, .pop, .done, .status, .reductions_done,
		.last_production, .stack_depth
	);

endmodule
`default_nettype wire

// ----- src/lrp_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_checker: port-level checks of the parse engine
// Result consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
module lrp_checker import lrp_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [2:0] status,
	input wire logic [6:0] reductions_done,
	input wire logic [7:0] last_production,
	input wire logic [8:0] stack_depth
);

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> stack_depth != 9'd0)
		else $error("empty state stack reported");

	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_IGNORED |-> reductions_done == 7'd0 && last_production == 8'd0)
		else $error("ignored token reported reductions");

	a_noreds: assert property (@(posedge clk) disable iff (!arst_n)
		done && reductions_done == 7'd0 |-> last_production == 8'd0)
		else $error("production reported without reduction");

	a_redmax: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> reductions_done <= MAX_REDS)
		else $error("reduction count beyond step limit");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(arst_n) || !$past(arst_n) |-> !done)
		else $error("result right after reset");

endmodule

bind lr_parse_engine_top lrp_checker u_chk (.*);
`default_nettype wire
